[hdl/pps_pkg.sv]
// Package for the preemptive priority scheduler: table depth, index widths,
// word types, cell command codes and controller states. No dependencies.
package pps_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = IDX_W;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] remain;
  } payload_t;

  typedef struct packed {
    logic     valid;
    payload_t data;
  } entry_t;

  typedef struct packed {
    logic             best_has;
    logic [7:0]       best_prio;
    logic [IDX_W-1:0] best_idx;
    logic [7:0]       best_id;
    logic             run_has;
    logic [7:0]       run_prio;
    logic [IDX_W-1:0] run_idx;
    logic [7:0]       run_id;
  } scan_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_APPEND,
    OP_RETIRE,
    OP_START
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic             sel_valid;
    logic [IDX_W-1:0] sel_idx;
    payload_t         new_data;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SCAN,
    ST_DECIDE,
    ST_DONE
  } state_t;

endpackage

[hdl/preemptive_priority_scheduler.sv]
// Preemptive priority scheduler: controller, result register and the row of
// task cells. Depends on pps_pkg and pps_cell.
//
// Each word on the input is either a task arrival or a scheduler tick, and
// gives exactly one result word. An arrival goes from acceptance to the
// ST_DONE state, which loads the result once the output register is free.
// A tick passes through ST_SHIFT, ST_SCAN and ST_DECIDE (default table depth
// 16): the gap left by a finished task closes by one cell per cycle, the
// priority search then walks the row of cells, one cell per cycle, and
// ST_DECIDE chooses the running task before the result is loaded.
// The input is taken again as soon as the previous result sits in the output
// register, whether or not it has been collected.
module preemptive_priority_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_task_id,
  input  logic [7:0]  in_task_priority,
  input  logic [15:0] in_burst_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_running_valid,
  output logic [7:0]  out_running_id,
  output logic        out_status
);
  import pps_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_valid_r, run_valid_nxt;
  logic [7:0]       run_id_r, run_id_nxt;
  logic             status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             res_valid_r, res_valid_nxt;
  logic [7:0]       res_id_r, res_id_nxt;
  logic             res_status_r, res_status_nxt;
  cell_ctrl_t       ctrl;
  logic             in_acc;
  logic             full;
  logic             switch_best;

  entry_t ent  [TABLE_DEPTH];
  logic   hole [TABLE_DEPTH];
  scan_t  scan [TABLE_DEPTH];

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      entry_t nbr_w;
      logic   prev_w;
      logic   hole_in_w;
      scan_t  scan_in_w;

      if (g == TABLE_DEPTH - 1) begin : g_top
        assign nbr_w = '0;
      end else begin : g_mid
        assign nbr_w = ent[g+1];
      end

      if (g == 0) begin : g_first
        assign prev_w    = 1'b1;
        assign hole_in_w = 1'b0;
        assign scan_in_w = '0;
      end else begin : g_rest
        assign prev_w    = ent[g-1].valid;
        assign hole_in_w = hole[g-1];
        assign scan_in_w = scan[g-1];
      end

      pps_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_idx   (IDX_W'(g)),
        .ctrl       (ctrl),
        .prev_valid (prev_w),
        .nbr        (nbr_w),
        .hole_in    (hole_in_w),
        .scan_in    (scan_in_w),
        .ent        (ent[g]),
        .hole       (hole[g]),
        .scan_out   (scan[g])
      );
    end
  endgenerate

  assign full        = ent[TABLE_DEPTH-1].valid;
  assign in_ready    = (state_r == ST_IDLE);
  assign in_acc      = in_valid && in_ready;
  assign switch_best = !scan[TABLE_DEPTH-1].run_has ||
                       (scan[TABLE_DEPTH-1].best_prio > scan[TABLE_DEPTH-1].run_prio);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    run_valid_nxt  = run_valid_r;
    run_id_nxt     = run_id_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    res_valid_nxt  = res_valid_r;
    res_id_nxt     = res_id_r;
    res_status_nxt = res_status_r;

    ctrl.op        = OP_NONE;
    ctrl.sel_valid = 1'b0;
    ctrl.sel_idx   = scan[TABLE_DEPTH-1].best_idx;
    ctrl.new_data.id     = in_task_id;
    ctrl.new_data.prio   = in_task_priority;
    ctrl.new_data.remain = in_burst_time;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_func) begin
            ctrl.op    = OP_APPEND;
            status_nxt = full;
            state_nxt  = ST_DONE;
          end else begin
            ctrl.op    = OP_RETIRE;
            status_nxt = 1'b0;
            cnt_nxt    = '0;
            state_nxt  = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(TABLE_DEPTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(TABLE_DEPTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        ctrl.op        = OP_START;
        ctrl.sel_valid = scan[TABLE_DEPTH-1].best_has;
        if (switch_best) begin
          ctrl.sel_idx = scan[TABLE_DEPTH-1].best_idx;
          run_id_nxt   = scan[TABLE_DEPTH-1].best_id;
        end else begin
          ctrl.sel_idx = scan[TABLE_DEPTH-1].run_idx;
          run_id_nxt   = scan[TABLE_DEPTH-1].run_id;
        end
        run_valid_nxt = scan[TABLE_DEPTH-1].best_has;
        if (!scan[TABLE_DEPTH-1].best_has) begin
          run_id_nxt = 8'd0;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          res_valid_nxt  = run_valid_r;
          res_id_nxt     = run_id_r;
          res_status_nxt = status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      run_valid_r <= 1'b0;
      run_id_r    <= 8'd0;
      status_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      run_valid_r <= run_valid_nxt;
      run_id_r    <= run_id_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_valid_r  <= res_valid_nxt;
    res_id_r     <= res_id_nxt;
    res_status_r <= res_status_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_running_valid = res_valid_r;
  assign out_running_id    = res_id_r;
  assign out_status        = res_status_r;

  a_idle_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !run_valid_r |-> (run_id_r == 8'd0))
    else $error("running id is not zero while nothing runs");

  a_decide_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE) |=> (run_valid_r == $past(scan[TABLE_DEPTH-1].best_has)))
    else $error("running flag disagrees with the search result");

  a_run_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE && scan[TABLE_DEPTH-1].run_has)
      |-> scan[TABLE_DEPTH-1].best_has)
    else $error("running task found in an empty table");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_func && full) |=> status_r)
    else $error("arrival into a full table not flagged");

endmodule

[hdl/pps_cell.sv]
// One slot of the scheduler's task row: holds a task, closes a gap by taking
// its upper neighbour's task, and forwards the running priority search.
// Depends on pps_pkg.
module pps_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [pps_pkg::IDX_W-1:0] cell_idx,
  input  pps_pkg::cell_ctrl_t      ctrl,
  input  logic                     prev_valid,
  input  pps_pkg::entry_t          nbr,
  input  logic                     hole_in,
  input  pps_pkg::scan_t           scan_in,
  output pps_pkg::entry_t          ent,
  output logic                     hole,
  output pps_pkg::scan_t           scan_out
);
  import pps_pkg::*;

  logic     valid_r, valid_nxt;
  logic     run_r, run_nxt;
  logic     hole_r, hole_nxt;
  payload_t data_r, data_nxt;
  scan_t    scan_r, scan_nxt;
  logic     pick;

  always_comb begin
    valid_nxt = valid_r;
    run_nxt   = run_r;
    hole_nxt  = 1'b0;
    data_nxt  = data_r;
    pick      = 1'b0;

    if (hole_r) begin
      valid_nxt = nbr.valid;
      data_nxt  = nbr.data;
      run_nxt   = 1'b0;
    end
    if (hole_in && valid_r) begin
      hole_nxt = 1'b1;
    end

    case (ctrl.op)
      OP_APPEND: begin
        if (!valid_r && prev_valid) begin
          valid_nxt = 1'b1;
          run_nxt   = 1'b0;
          data_nxt  = ctrl.new_data;
        end
      end
      OP_RETIRE: begin
        if (valid_r && run_r && (data_r.remain == 16'd0)) begin
          hole_nxt = 1'b1;
          run_nxt  = 1'b0;
        end
      end
      OP_START: begin
        pick    = valid_r && ctrl.sel_valid && (cell_idx == ctrl.sel_idx);
        run_nxt = pick;
        if (pick && (data_r.remain != 16'd0)) begin
          data_nxt.remain = data_r.remain - 16'd1;
        end
      end
      default: begin
      end
    endcase

    scan_nxt = scan_in;
    if (valid_r && (!scan_in.best_has || (data_r.prio >= scan_in.best_prio))) begin
      scan_nxt.best_has  = 1'b1;
      scan_nxt.best_prio = data_r.prio;
      scan_nxt.best_idx  = cell_idx;
      scan_nxt.best_id   = data_r.id;
    end
    if (valid_r && run_r) begin
      scan_nxt.run_has  = 1'b1;
      scan_nxt.run_prio = data_r.prio;
      scan_nxt.run_idx  = cell_idx;
      scan_nxt.run_id   = data_r.id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      run_r   <= 1'b0;
      hole_r  <= 1'b0;
      scan_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      run_r   <= run_nxt;
      hole_r  <= hole_nxt;
      scan_r  <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign ent.valid = valid_r;
  assign ent.data  = data_r;
  assign hole      = hole_r;
  assign scan_out  = scan_r;

endmodule
